>>> sv/screen_sleep_power_state_machine_top_assert.svh
// Assertion macros for the screen sleep power state machine.
`ifndef SCREEN_SLEEP_POWER_STATE_MACHINE_TOP_ASSERT_SVH
`define SCREEN_SLEEP_POWER_STATE_MACHINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define SSPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sspm assertion failed");

// Next-cycle implication, checked out of reset.
`define SSPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sspm assertion failed");

`else

`define SSPM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SSPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/sspm_pkg.sv
// Shared types and codes for the screen sleep power state machine.
`default_nettype none

package sspm_pkg;

    localparam int COUNT_BITS_DEF = 11;

    // Power state codes as seen on the result channel
    localparam logic [1:0] PWR_ACTIVE = 2'd0;
    localparam logic [1:0] PWR_OFF    = 2'd1;
    localparam logic [1:0] PWR_SLEEP  = 2'd2;

    // Item commands
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_WAKE   = 2'd1;
    localparam logic [1:0] CMD_MANUAL = 2'd2;

    // Wake causes
    localparam logic [1:0] CAUSE_TIMER = 2'd1;

    // Fade actions
    localparam logic [1:0] FADE_NONE = 2'd0;
    localparam logic [1:0] FADE_OFF  = 2'd1;
    localparam logic [1:0] FADE_ON   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_FACE_DOWN_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_SLEEP_TIMEOUT     = 2'd1;
    localparam logic [1:0] REG_IDLE_TIMEOUT      = 2'd2;
    localparam logic [1:0] REG_DFLT_LEVEL        = 2'd3;

    localparam int CFG_DATA_BITS = 11;

    typedef struct packed {
        logic [1:0] cmd;
        logic       face_down;
        logic       touch;
        logic       moving;
        logic       sleep_inhibit;
        logic [7:0] current_backlight;
        logic [1:0] wake_src;
    } item_t;

    typedef struct packed {
        logic [1:0] power_state;
        logic       state_changed;
        logic [1:0] previous_state;
        logic [1:0] fade_action;
        logic [7:0] restore_level;
        logic       arm_wake_sources;
        logic       sleep_blocked;
    } result_t;

    typedef struct packed {
        logic [9:0]  face_down_timeout_s;
        logic [10:0] sleep_timeout_s;
        logic [10:0] idle_timeout_s;
        logic [7:0]  dflt_level;
    } cfg_t;

endpackage

`default_nettype wire

>>> sv/sspm_if.sv
// Valid/ready channel interfaces for items and results.
`default_nettype none

interface sspm_item_if;
    import sspm_pkg::*;

    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sspm_result_if;
    import sspm_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/screen_sleep_power_state_machine_top.sv
// Top level of the screen sleep power state machine.
`default_nettype none
`include "screen_sleep_power_state_machine_top_assert.svh"

// Usage
//   item_ch   : valid/ready sink, one transaction per poll tick, sleep wake
//               event or manual wake request (cmd field selects which).
//   result_ch : valid/ready source, exactly one transaction per item, in order:
//               new and previous power state, fade action, restore level,
//               wake arming and the sleep-blocked flag.
//   cfg_*     : write-only register port (face-down timeout, sleep timeout,
//               idle timeout, default backlight); write only while idle.
// Timing
//   An item waits in the input register until the result register is free or
//   being taken; the state machine then updates and loads the result register.
//   Throughput is one item per cycle while result_ch does not stall, set by the
//   combinational next-state logic between input and result registers.
// Reset
//   rst_n clears both stages, puts the machine in active with all counters at
//   zero and saved level 255, and loads the register defaults.
// Stall
//   A stalled result holds; the input register still takes one more item, so
//   item_ch.ready drops only while both stages are full and result_ch stalls.

module screen_sleep_power_state_machine_top #(
    parameter int COUNT_BITS = sspm_pkg::COUNT_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    sspm_item_if.sink                               item_ch,
    sspm_result_if.source                           result_ch,
    input  wire logic                               cfg_we,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic [sspm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import sspm_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    logic    advance;
    result_t result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.face_down_timeout_s <= 10'd30;
            cfg_reg.sleep_timeout_s     <= 11'd300;
            cfg_reg.idle_timeout_s      <= 11'd0;
            cfg_reg.dflt_level          <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FACE_DOWN_TIMEOUT: cfg_reg.face_down_timeout_s <= cfg_data[9:0];
                REG_SLEEP_TIMEOUT:     cfg_reg.sleep_timeout_s     <= cfg_data[10:0];
                REG_IDLE_TIMEOUT:      cfg_reg.idle_timeout_s      <= cfg_data[10:0];
                REG_DFLT_LEVEL:        cfg_reg.dflt_level          <= cfg_data[7:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    // an item moves into the state machine when the result slot frees up
    assign advance       = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign item_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ch.valid && item_ch.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ch.valid && item_ch.ready)
            in_item_reg <= item_ch.payload;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result_ch.ready)
            out_valid_reg <= 1'b0;
    end

    sspm_fsm #(
        .COUNT_BITS (COUNT_BITS)
    ) u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign result_ch.valid   = out_valid_reg;
    assign result_ch.payload = result;

    // a moved item always shows up as a result on the next cycle
    `SSPM_ASSERT_NEXT(a_advance_gives_result, clk, rst_n, advance, out_valid_reg)
    // input stalls only when both stages hold a transaction
    `SSPM_ASSERT_NOW(a_stall_only_full, clk, rst_n, !item_ch.ready,
                     in_valid_reg && out_valid_reg)
    // arming wake sources happens only on the screen-off to sleep transition
    `SSPM_ASSERT_NOW(a_arm_on_sleep_entry, clk, rst_n,
                     out_valid_reg && result.arm_wake_sources,
                     result.power_state == PWR_SLEEP && result.previous_state == PWR_OFF)
    // a blocked sleep leaves the screen off
    `SSPM_ASSERT_NOW(a_blocked_stays_off, clk, rst_n,
                     out_valid_reg && result.sleep_blocked,
                     result.power_state == PWR_OFF && !result.state_changed)
    // fade on accompanies every wake into active
    `SSPM_ASSERT_NOW(a_fade_on_wakes, clk, rst_n,
                     out_valid_reg && result.fade_action == FADE_ON,
                     result.power_state == PWR_ACTIVE && result.state_changed)

endmodule

`default_nettype wire

>>> sv/sspm_fsm.sv
// Power state machine: counters, saved backlight level and result register.
`default_nettype none

module sspm_fsm #(
    parameter int COUNT_BITS = sspm_pkg::COUNT_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire sspm_pkg::item_t item,
    input  wire sspm_pkg::cfg_t  cfg,
    output sspm_pkg::result_t    result
);
    import sspm_pkg::*;

    typedef enum logic [1:0] {
        ST_ACTIVE = PWR_ACTIVE,
        ST_OFF    = PWR_OFF,
        ST_SLEEP  = PWR_SLEEP
    } state_t;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    state_t                mode_reg, mode_next;
    logic                  seen_reg, seen_next;
    logic [COUNT_BITS-1:0] fd_secs_reg, fd_secs_next;
    logic [COUNT_BITS-1:0] idle_secs_reg, idle_secs_next;
    logic [COUNT_BITS-1:0] off_secs_reg, off_secs_next;
    logic [7:0]            saved_reg, saved_next;
    result_t               result_reg, result_next;

    logic                  activity;
    logic                  go_off;
    logic                  wake;
    logic [COUNT_BITS-1:0] fd_inc, idle_inc, off_inc;
    logic [11:0]           delay;
    logic                  delay_pos;
    logic [1:0]            fade;
    logic                  arm;
    logic                  blocked;

    assign activity  = item.touch | item.moving;
    assign fd_inc    = (fd_secs_reg == CNT_MAX) ? CNT_MAX : fd_secs_reg + CNT_ONE;
    assign idle_inc  = (idle_secs_reg == CNT_MAX) ? CNT_MAX : idle_secs_reg + CNT_ONE;
    assign off_inc   = (off_secs_reg == CNT_MAX) ? CNT_MAX : off_secs_reg + CNT_ONE;
    // signed sleep delay: sleep timeout minus face-down timeout
    assign delay     = {1'b0, cfg.sleep_timeout_s} - {2'b00, cfg.face_down_timeout_s};
    assign delay_pos = !delay[11] && (delay != 12'd0);

    always_comb
    begin
        mode_next      = mode_reg;
        seen_next      = seen_reg;
        fd_secs_next   = fd_secs_reg;
        idle_secs_next = idle_secs_reg;
        off_secs_next  = off_secs_reg;
        saved_next     = saved_reg;
        fade           = FADE_NONE;
        arm            = 1'b0;
        blocked        = 1'b0;
        go_off         = 1'b0;
        wake           = 1'b0;

        case (item.cmd)
            CMD_TICK:
            begin
                if (mode_reg != ST_SLEEP)
                begin
                    idle_secs_next = activity ? '0 : idle_inc;
                    if (mode_reg == ST_ACTIVE)
                    begin
                        if (item.face_down)
                        begin
                            if (!seen_reg)
                            begin
                                seen_next    = 1'b1;
                                fd_secs_next = '0;
                            end
                            else
                            begin
                                fd_secs_next = fd_inc;
                                if (fd_inc >= COUNT_BITS'(cfg.face_down_timeout_s))
                                    go_off = 1'b1;
                            end
                        end
                        else
                        begin
                            seen_next    = 1'b0;
                            fd_secs_next = '0;
                        end
                        if (cfg.idle_timeout_s != '0 &&
                            idle_secs_next >= COUNT_BITS'(cfg.idle_timeout_s))
                            go_off = 1'b1;
                        if (go_off)
                        begin
                            saved_next    = (item.current_backlight == 8'd0) ?
                                            cfg.dflt_level : item.current_backlight;
                            mode_next     = ST_OFF;
                            off_secs_next = '0;
                            fade          = FADE_OFF;
                        end
                    end
                    else if (activity || (!item.face_down && seen_reg))
                    begin
                        wake = 1'b1;
                    end
                    else
                    begin
                        off_secs_next = off_inc;
                        if (delay_pos && off_inc >= COUNT_BITS'(delay[10:0]))
                        begin
                            if (item.sleep_inhibit)
                                blocked = 1'b1;
                            else
                            begin
                                mode_next = ST_SLEEP;
                                arm       = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_WAKE:
            begin
                // a timer wake while still face down keeps sleeping
                if (mode_reg == ST_SLEEP &&
                    (item.wake_src != CAUSE_TIMER || !item.face_down))
                    wake = 1'b1;
            end
            CMD_MANUAL:
            begin
                if (mode_reg != ST_ACTIVE)
                    wake = 1'b1;
            end
            default:
            begin
                wake = 1'b0;
            end
        endcase

        if (wake)
        begin
            mode_next      = ST_ACTIVE;
            seen_next      = 1'b0;
            fd_secs_next   = '0;
            off_secs_next  = '0;
            idle_secs_next = '0;
            fade           = FADE_ON;
        end

        result_next.power_state      = mode_next;
        result_next.state_changed    = (mode_next != mode_reg);
        result_next.previous_state   = mode_reg;
        result_next.fade_action      = fade;
        result_next.restore_level    = saved_next;
        result_next.arm_wake_sources = arm;
        result_next.sleep_blocked    = blocked;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ST_ACTIVE;
            seen_reg      <= 1'b0;
            fd_secs_reg   <= '0;
            idle_secs_reg <= '0;
            off_secs_reg  <= '0;
            saved_reg     <= 8'd255;
            result_reg    <= '0;
        end
        else if (load)
        begin
            mode_reg      <= mode_next;
            seen_reg      <= seen_next;
            fd_secs_reg   <= fd_secs_next;
            idle_secs_reg <= idle_secs_next;
            off_secs_reg  <= off_secs_next;
            saved_reg     <= saved_next;
            result_reg    <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> tb/sv/screen_sleep_power_state_machine_top_tb.sv
// Self-checking testbench for the screen sleep power state machine top level.
`timescale 1ns / 1ps

module screen_sleep_power_state_machine_top_tb;
    import sspm_pkg::*;

    localparam int COUNT_BITS = COUNT_BITS_DEF;

    // Codes the package leaves unnamed
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [1:0] CAUSE_TOUCH  = 2'd0;
    localparam logic [1:0] CAUSE_OTHER  = 2'd2;
    localparam logic [1:0] CAUSE_UNUSED = 2'd3;

    // Longest quiet stretch: the long result hold-off, plus rare long random
    // stall runs at 80 percent; the watchdog limit is far beyond both.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 60;
    localparam int NUM_PHASES     = 7;

    typedef logic [COUNT_BITS-1:0] secs_t;
    localparam secs_t SECS_MAX = '1;

    // Random stimulus shapes: how the device is being handled for a while
    typedef enum logic [1:0] {LIE_FACE_DOWN, SIT_IDLE, IN_USE, JUNK} handling_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [1:0]               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    sspm_item_if   item_ch ();
    sspm_result_if result_ch ();

    screen_sleep_power_state_machine_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Phase plan: register settings, transactions sent, idling
    int unsigned ph_fd    [NUM_PHASES] = '{10, 12, 20, 60, 10, 600, 30};
    int unsigned ph_sleep [NUM_PHASES] = '{60, 70, 60, 60, 1800, 60, 300};
    int unsigned ph_idle  [NUM_PHASES] = '{0, 5, 8, 3, 1800, 2, 0};
    int unsigned ph_dflt  [NUM_PHASES] = '{255, 90, 1, 200, 255, 1, 255};
    int unsigned ph_items [NUM_PHASES] = '{300, 250, 250, 200, 150, 150, 150};
    int unsigned ph_src   [NUM_PHASES] = '{0, 0, 80, 0, 11, 11, 80};
    int unsigned ph_snk   [NUM_PHASES] = '{0, 0, 0, 80, 11, 11, 0};

    // Power model state and its copy of the registers
    cfg_t        model_cfg;
    logic [1:0]  model_mode;
    logic        model_fd_seen;
    secs_t       model_fd_secs;
    secs_t       model_idle_secs;
    secs_t       model_off_secs;
    logic [7:0]  model_saved_level;

    result_t     pending_reports [$];
    result_t     oldest_report;

    // Directed table
    item_t       dir_items [$];
    bit          dir_typed [$];
    result_t     dir_wants [$];

    // Random sequence state
    handling_t   handling;
    int unsigned seq_left;
    bit          seq_inhibit;

    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned hold_left;
    int unsigned quiet_cycles;
    int unsigned errors;
    int unsigned acted_items;
    int unsigned sent_items;
    int unsigned report_count;
    int unsigned sleep_entries;
    int unsigned blocked_count;
    int unsigned wakes;

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic secs_t sat_up(input secs_t v);
        return (v == SECS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic item_t mk_item(input logic [1:0] cmd, input logic fd, input logic touch,
                                      input logic moving, input logic inhibit,
                                      input logic [7:0] level, input logic [1:0] cause);
        item_t it;
        it.cmd               = cmd;
        it.face_down         = fd;
        it.touch             = touch;
        it.moving            = moving;
        it.sleep_inhibit     = inhibit;
        it.current_backlight = level;
        it.wake_src          = cause;
        return it;
    endfunction

    function automatic result_t mk_report(input logic [1:0] state, input logic changed,
                                          input logic [1:0] prev, input logic [1:0] fade,
                                          input logic [7:0] level, input logic arm,
                                          input logic blocked);
        result_t r;
        r.power_state      = state;
        r.state_changed    = changed;
        r.previous_state   = prev;
        r.fade_action      = fade;
        r.restore_level    = level;
        r.arm_wake_sources = arm;
        r.sleep_blocked    = blocked;
        return r;
    endfunction

    task automatic reset_power_model();
        model_cfg.face_down_timeout_s = 10'd30;
        model_cfg.sleep_timeout_s     = 11'd300;
        model_cfg.idle_timeout_s      = 11'd0;
        model_cfg.dflt_level          = 8'd255;
        model_mode        = PWR_ACTIVE;
        model_fd_seen     = 1'b0;
        model_fd_secs     = '0;
        model_idle_secs   = '0;
        model_off_secs    = '0;
        model_saved_level = 8'd255;
    endtask

    // Applies one accepted transaction to the model and returns its report.
    // acted is low when the block has nothing to do with the transaction.
    task automatic predict_power_report(input item_t it, output result_t r, output bit acted);
        logic [1:0] prev;
        logic [1:0] fade;
        logic       arm;
        logic       blocked;
        logic       activity;
        logic       go_dark;
        logic       wake;
        int         sleep_gap;
        prev     = model_mode;
        fade     = FADE_NONE;
        arm      = 1'b0;
        blocked  = 1'b0;
        go_dark  = 1'b0;
        wake     = 1'b0;
        acted    = 1'b1;
        activity = it.touch | it.moving;
        if (it.cmd == CMD_TICK && model_mode != PWR_SLEEP)
        begin
            model_idle_secs = activity ? '0 : sat_up(model_idle_secs);
            if (model_mode == PWR_ACTIVE)
            begin
                if (it.face_down)
                begin
                    // first face-down tick only arms the count
                    if (!model_fd_seen)
                    begin
                        model_fd_seen = 1'b1;
                        model_fd_secs = '0;
                    end
                    else
                    begin
                        model_fd_secs = sat_up(model_fd_secs);
                        if (model_fd_secs >= model_cfg.face_down_timeout_s)
                            go_dark = 1'b1;
                    end
                end
                else
                begin
                    model_fd_seen = 1'b0;
                    model_fd_secs = '0;
                end
                if (!go_dark && model_cfg.idle_timeout_s != 0 &&
                    model_idle_secs >= model_cfg.idle_timeout_s)
                    go_dark = 1'b1;
                if (go_dark)
                begin
                    model_saved_level = (it.current_backlight == 8'd0) ?
                                        model_cfg.dflt_level : it.current_backlight;
                    model_mode     = PWR_OFF;
                    model_off_secs = '0;
                    fade           = FADE_OFF;
                end
            end
            else if (activity || (!it.face_down && model_fd_seen))
            begin
                wake = 1'b1;
            end
            else
            begin
                sleep_gap = int'(model_cfg.sleep_timeout_s) -
                            int'(model_cfg.face_down_timeout_s);
                model_off_secs = sat_up(model_off_secs);
                if (sleep_gap > 0 && int'(model_off_secs) >= sleep_gap)
                begin
                    if (it.sleep_inhibit)
                        blocked = 1'b1;
                    else
                    begin
                        model_mode = PWR_SLEEP;
                        arm        = 1'b1;
                    end
                end
            end
        end
        else if (it.cmd == CMD_WAKE && model_mode == PWR_SLEEP)
        begin
            // a timer wake while still face down goes back to sleep
            if (it.wake_src != CAUSE_TIMER || !it.face_down)
                wake = 1'b1;
        end
        else if (it.cmd == CMD_MANUAL && model_mode != PWR_ACTIVE)
        begin
            wake = 1'b1;
        end
        else
        begin
            acted = 1'b0;
        end
        if (wake)
        begin
            model_mode      = PWR_ACTIVE;
            model_fd_seen   = 1'b0;
            model_fd_secs   = '0;
            model_off_secs  = '0;
            model_idle_secs = '0;
            fade            = FADE_ON;
            wakes++;
        end
        if (arm)
            sleep_entries++;
        if (blocked)
            blocked_count++;
        r = mk_report(model_mode, model_mode != prev, prev, fade, model_saved_level,
                      arm, blocked);
    endtask

    // Called at a falling edge; returns at a falling edge after acceptance.
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        result_t r;
        bit      acted;
        while (chance(src_idle_pct))
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predict_power_report(it, r, acted);
        pending_reports.push_back(typed ? want : r);
        sent_items++;
        if (acted)
            acted_items++;
        @(negedge clk);
    endtask

    // Sender pause until every report is back, plus the pipeline latency
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_registers(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FACE_DOWN_TIMEOUT;
        cfg_data  <= {1'b0, c.face_down_timeout_s};
        @(negedge clk);
        cfg_index <= REG_SLEEP_TIMEOUT;
        cfg_data  <= c.sleep_timeout_s;
        @(negedge clk);
        cfg_index <= REG_IDLE_TIMEOUT;
        cfg_data  <= c.idle_timeout_s;
        @(negedge clk);
        cfg_index <= REG_DFLT_LEVEL;
        cfg_data  <= {3'b000, c.dflt_level};
        @(negedge clk);
        cfg_we    <= 1'b0;
        model_cfg = c;
        @(negedge clk);
    endtask

    task automatic table_row(input item_t it, input bit typed, input result_t want);
        dir_items.push_back(it);
        dir_typed.push_back(typed);
        dir_wants.push_back(want);
    endtask

    // Mostly believable handling: lying face down, sitting idle, in use.
    // Wake events and manual wakes follow the model's current state.
    task automatic next_random_item(output item_t it);
        int unsigned pick;
        if (seq_left == 0)
        begin
            pick        = $urandom_range(9);
            handling    = (pick < 3) ? LIE_FACE_DOWN : (pick < 6) ? SIT_IDLE :
                          (pick < 9) ? IN_USE : JUNK;
            seq_left    = $urandom_range(5, 90);
            seq_inhibit = chance(30);
        end
        seq_left--;
        it = item_t'($urandom);
        if (handling != JUNK)
        begin
            it.sleep_inhibit = seq_inhibit;
            if (chance(10))
                it.current_backlight = 8'd0;
            else if (chance(10))
                it.current_backlight = 8'd255;
            case (handling)
                LIE_FACE_DOWN:
                begin
                    it.face_down = 1'b1;
                    it.touch     = chance(4);
                    it.moving    = chance(4);
                end
                SIT_IDLE:
                begin
                    it.face_down = chance(5);
                    it.touch     = chance(3);
                    it.moving    = chance(3);
                end
                default:
                begin
                    it.face_down = chance(20);
                    it.touch     = chance(40);
                    it.moving    = chance(40);
                end
            endcase
            if (model_mode == PWR_SLEEP && chance(20))
                it.cmd = chance(70) ? CMD_WAKE : CMD_MANUAL;
            else if (model_mode == PWR_OFF && chance(3))
                it.cmd = CMD_MANUAL;
            else
                it.cmd = CMD_TICK;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result sink: random stalls, plus a long hold-off when requested
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= !chance(snk_stall_pct);
        end
    end

    // Report checker, one field at a time against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            report_count++;
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected report %h", $time, result_ch.payload);
            end
            else
            begin
                oldest_report = pending_reports.pop_front();
                check_field("power_state", oldest_report.power_state,
                            result_ch.payload.power_state);
                check_field("state_changed", oldest_report.state_changed,
                            result_ch.payload.state_changed);
                check_field("previous_state", oldest_report.previous_state,
                            result_ch.payload.previous_state);
                check_field("fade_action", oldest_report.fade_action,
                            result_ch.payload.fade_action);
                check_field("restore_level", oldest_report.restore_level,
                            result_ch.payload.restore_level);
                check_field("arm_wake_sources", oldest_report.arm_wake_sources,
                            result_ch.payload.arm_wake_sources);
                check_field("sleep_blocked", oldest_report.sleep_blocked,
                            result_ch.payload.sleep_blocked);
            end
        end
    end

    // Watchdog: too long without any transaction on either channel
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        item_t it;
        cfg_t  c;
        int unsigned start;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        hold_left       = 0;
        errors          = 0;
        acted_items     = 0;
        sent_items      = 0;
        report_count    = 0;
        sleep_entries   = 0;
        blocked_count   = 0;
        wakes           = 0;
        seq_left        = 0;
        seq_inhibit     = 1'b0;
        handling        = SIT_IDLE;
        reset_power_model();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: face-down timeout 59 against sleep timeout 60 gives
        // a one-second sleep delay; idle timeout 1 turns off on any quiet tick;
        // default backlight 1 is the lowest legal level.
        c.face_down_timeout_s = 10'd59;
        c.sleep_timeout_s     = 11'd60;
        c.idle_timeout_s      = 11'd1;
        c.dflt_level          = 8'd1;
        load_registers(c);

        // busy tick, then the three ignored commands while active
        table_row(mk_item(CMD_TICK, 0, 1, 0, 0, 8'd0, CAUSE_TOUCH), 1,
                  mk_report(PWR_ACTIVE, 0, PWR_ACTIVE, FADE_NONE, 8'd255, 0, 0));
        table_row(mk_item(CMD_MANUAL, 0, 0, 0, 0, 8'd0, CAUSE_TOUCH), 1,
                  mk_report(PWR_ACTIVE, 0, PWR_ACTIVE, FADE_NONE, 8'd255, 0, 0));
        table_row(mk_item(CMD_WAKE, 0, 0, 0, 0, 8'd0, CAUSE_TOUCH), 1,
                  mk_report(PWR_ACTIVE, 0, PWR_ACTIVE, FADE_NONE, 8'd255, 0, 0));
        table_row(mk_item(CMD_UNUSED, 1, 1, 1, 1, 8'd255, CAUSE_UNUSED), 1,
                  mk_report(PWR_ACTIVE, 0, PWR_ACTIVE, FADE_NONE, 8'd255, 0, 0));
        // idle timeout with a zero level read saves the default level
        table_row(mk_item(CMD_TICK, 0, 0, 0, 0, 8'd0, CAUSE_TOUCH), 1,
                  mk_report(PWR_OFF, 1, PWR_ACTIVE, FADE_OFF, 8'd1, 0, 0));
        table_row(mk_item(CMD_TICK, 0, 0, 1, 0, 8'd0, CAUSE_TOUCH), 1,
                  mk_report(PWR_ACTIVE, 1, PWR_OFF, FADE_ON, 8'd1, 0, 0));
        table_row(mk_item(CMD_TICK, 0, 0, 0, 0, 8'd255, CAUSE_TOUCH), 1,
                  mk_report(PWR_OFF, 1, PWR_ACTIVE, FADE_OFF, 8'd255, 0, 0));
        // sleep delay reached: inhibited once, then taken
        table_row(mk_item(CMD_TICK, 0, 0, 0, 1, 8'd0, CAUSE_TOUCH), 1,
                  mk_report(PWR_OFF, 0, PWR_OFF, FADE_NONE, 8'd255, 0, 1));
        table_row(mk_item(CMD_TICK, 0, 0, 0, 0, 8'd0, CAUSE_TOUCH), 1,
                  mk_report(PWR_SLEEP, 1, PWR_OFF, FADE_NONE, 8'd255, 1, 0));
        // tick and unused command in light sleep change nothing
        table_row(mk_item(CMD_TICK, 0, 1, 1, 0, 8'd0, CAUSE_TOUCH), 1,
                  mk_report(PWR_SLEEP, 0, PWR_SLEEP, FADE_NONE, 8'd255, 0, 0));
        table_row(mk_item(CMD_UNUSED, 0, 0, 0, 0, 8'd0, CAUSE_TOUCH), 1,
                  mk_report(PWR_SLEEP, 0, PWR_SLEEP, FADE_NONE, 8'd255, 0, 0));
        // timer wake: face down stays asleep, face up wakes
        table_row(mk_item(CMD_WAKE, 1, 0, 0, 0, 8'd0, CAUSE_TIMER), 0, '0);
        table_row(mk_item(CMD_WAKE, 0, 0, 0, 0, 8'd0, CAUSE_TIMER), 0, '0);
        table_row(mk_item(CMD_TICK, 0, 0, 0, 0, 8'h80, CAUSE_TOUCH), 0, '0);
        // wake event outside light sleep
        table_row(mk_item(CMD_WAKE, 0, 0, 0, 0, 8'd0, CAUSE_OTHER), 0, '0);
        table_row(mk_item(CMD_TICK, 0, 0, 0, 0, 8'd0, CAUSE_TOUCH), 0, '0);
        // unused cause wakes even face down
        table_row(mk_item(CMD_WAKE, 1, 0, 0, 0, 8'd0, CAUSE_UNUSED), 0, '0);
        table_row(mk_item(CMD_TICK, 0, 0, 0, 0, 8'h2C, CAUSE_TOUCH), 0, '0);
        table_row(mk_item(CMD_TICK, 0, 0, 0, 0, 8'd0, CAUSE_TOUCH), 0, '0);
        table_row(mk_item(CMD_WAKE, 1, 0, 0, 0, 8'd0, CAUSE_TOUCH), 0, '0);
        // first face-down tick only marks it; pickup then wakes from off
        table_row(mk_item(CMD_TICK, 1, 1, 0, 0, 8'd0, CAUSE_TOUCH), 0, '0);
        table_row(mk_item(CMD_TICK, 1, 0, 0, 0, 8'h17, CAUSE_TOUCH), 0, '0);
        table_row(mk_item(CMD_TICK, 0, 0, 0, 0, 8'd0, CAUSE_TOUCH), 0, '0);
        table_row(mk_item(CMD_TICK, 0, 0, 0, 0, 8'hE8, CAUSE_TOUCH), 0, '0);
        table_row(mk_item(CMD_MANUAL, 0, 0, 0, 0, 8'd0, CAUSE_TOUCH), 0, '0);

        foreach (dir_items[i])
            send_item(dir_items[i], dir_typed[i], dir_wants[i]);

        // Random phases, each under its own register setting and idling mix
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            c.face_down_timeout_s = 10'(ph_fd[p]);
            c.sleep_timeout_s     = 11'(ph_sleep[p]);
            c.idle_timeout_s      = 11'(ph_idle[p]);
            c.dflt_level          = 8'(ph_dflt[p]);
            load_registers(c);
            src_idle_pct  = ph_src[p];
            snk_stall_pct = ph_snk[p];
            if (p == 1)
            begin
                // long result hold-off while items keep coming: fills both
                // stages and stalls the input
                @(posedge clk);
                hold_left = LONG_HOLD;
                @(negedge clk);
            end
            start = sent_items;
            while (sent_items - start < ph_items[p])
            begin
                next_random_item(it);
                send_item(it, 1'b0, '0);
            end
        end

        item_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d transactions (%0d handled) over %0d register settings, %0d checked.",
                 sent_items, acted_items, NUM_PHASES + 1, report_count);
        $display("Light sleep entered %0d times, %0d sleeps held off by inhibit, %0d wakes.",
                 sleep_entries, blocked_count, wakes);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
